### sv/ofph_pkg.sv
// Shared types and constants for the optical-flow position-hold PD block.
`timescale 1ns / 1ps

package ofph_pkg;

  localparam int POS_W      = 32;             // position accumulator width
  localparam int GAIN_W     = 16;             // Q8.8 gains
  localparam int DELTA_W    = 8;
  localparam int STATUS_W   = 8;
  localparam int DRIVE_W    = 15;
  localparam int MOTION_BIT = 7;
  localparam int DIVISOR    = 100;
  localparam int DRIVE_LIMIT = 60 * 256;      // 60.0 in Q8.8

  // Divide by 100 through a reciprocal: estimate is exact or one low.
  localparam int DIV_SH  = POS_W + 5;
  localparam logic [63:0] RECIP_FULL = (64'd1 << DIV_SH) / 64'(DIVISOR);
  localparam int RECIP_W = POS_W - 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam int PROD_W  = POS_W + RECIP_W;
  localparam int QMAG_W  = PROD_W - DIV_SH;   // quotient, signed, fits
  localparam int REM_W   = 8;                 // remainder estimate < 200

  localparam int PT_W  = GAIN_W + QMAG_W;     // proportional product
  localparam int DT_W  = GAIN_W + 1;          // negated derivative term
  localparam int SUM_W = PT_W + 2;

  localparam int NSTG = 5;                    // lane pipeline stages

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GAIN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 1'b0,
    CFG_DERIV_GAIN = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic            taken;   // report carries new motion
    logic [NSTG-1:0] ld;      // per-stage load enables, ld[0] = beat accepted
  } lane_ctl_t;

  typedef struct packed {
    logic signed [PT_W-1:0] pterm;  // prop_gain * (position / 100)
    logic signed [DT_W-1:0] dterm;  // -deriv_gain * (delta / 100)
  } lane_res_t;

endpackage

### sv/ofph_lane.sv
// One axis: saturating position accumulator, divide by 100 and gain products.
`timescale 1ns / 1ps

module ofph_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ofph_pkg::lane_ctl_t                   ctl_i,
  input  logic [ofph_pkg::DELTA_W-1:0]          raw_delta_i,
  input  logic signed [ofph_pkg::GAIN_W-1:0]    prop_gain_i,
  input  logic signed [ofph_pkg::GAIN_W-1:0]    deriv_gain_i,
  output ofph_pkg::lane_res_t                   res_o
);
  import ofph_pkg::*;

  localparam logic signed [DELTA_W-1:0] D_HI = DELTA_W'(DIVISOR);
  localparam logic signed [DELTA_W-1:0] D_LO = -D_HI;
  localparam logic [REM_W-1:0]          REM_DIV = REM_W'(DIVISOR);
  localparam logic [POS_W-1:0]          POS_DIV = POS_W'(DIVISOR);

  // architectural state
  logic signed [POS_W-1:0]   pos_q, pos_d;
  logic signed [DELTA_W-1:0] delta_q, delta_d;

  // stage 0: snapshot
  logic [POS_W-1:0]          mag0_q;
  logic                      neg0_q, dp0_q, dn0_q;
  // stage 1: reciprocal product
  logic [PROD_W-1:0]         prod1_q;
  logic [POS_W-1:0]          mag1_q;
  logic                      neg1_q, dp1_q, dn1_q;
  // stage 2: quotient estimate and remainder
  logic [QMAG_W-1:0]         qest2_q;
  logic [REM_W-1:0]          rem2_q;
  logic                      neg2_q, dp2_q, dn2_q;
  // stage 3: corrected signed quotient
  logic signed [QMAG_W-1:0]  quot3_q;
  logic                      dp3_q, dn3_q;
  // stage 4: terms
  logic signed [PT_W-1:0]    pterm4_q;
  logic signed [DT_W-1:0]    dterm4_q;

  logic signed [POS_W:0]     pos_sum;
  logic [POS_W-1:0]          rem_full;
  logic                      corr;
  logic signed [QMAG_W-1:0]  quot_d;

  always_comb begin
    pos_sum = {pos_q[POS_W-1], pos_q} + (POS_W+1)'(signed'(raw_delta_i));
    pos_d   = pos_q;
    delta_d = delta_q;
    if (ctl_i.taken) begin
      delta_d = signed'(raw_delta_i);
      if (pos_sum[POS_W] != pos_sum[POS_W-1]) begin
        pos_d = pos_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
        pos_d = pos_sum[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      delta_q <= '0;
    end else begin
      pos_q   <= pos_d;
      delta_q <= delta_d;
    end
  end

  assign rem_full = mag1_q - POS_W'(prod1_q[PROD_W-1:DIV_SH]) * POS_DIV;
  assign corr     = (rem2_q >= REM_DIV);
  // -(q + c) == ~q + 1 - c
  assign quot_d   = neg2_q ? signed'(~qest2_q + QMAG_W'(!corr))
                           : signed'(qest2_q + QMAG_W'(corr));

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[0]) begin
      neg0_q <= pos_d[POS_W-1];
      mag0_q <= pos_d[POS_W-1] ? (~pos_d + POS_W'(1)) : pos_d;
      dp0_q  <= (delta_d >= D_HI);
      dn0_q  <= (delta_d <= D_LO);
    end
    if (ctl_i.ld[1]) begin
      prod1_q <= PROD_W'(mag0_q) * PROD_W'(RECIP);
      mag1_q  <= mag0_q;
      neg1_q  <= neg0_q;
      dp1_q   <= dp0_q;
      dn1_q   <= dn0_q;
    end
    if (ctl_i.ld[2]) begin
      qest2_q <= prod1_q[PROD_W-1:DIV_SH];
      rem2_q  <= rem_full[REM_W-1:0];
      neg2_q  <= neg1_q;
      dp2_q   <= dp1_q;
      dn2_q   <= dn1_q;
    end
    if (ctl_i.ld[3]) begin
      quot3_q <= quot_d;
      dp3_q   <= dp2_q;
      dn3_q   <= dn2_q;
    end
    if (ctl_i.ld[4]) begin
      pterm4_q <= PT_W'(prop_gain_i) * PT_W'(quot3_q);
      if (dp3_q) begin
        dterm4_q <= -DT_W'(deriv_gain_i);
      end else if (dn3_q) begin
        dterm4_q <= DT_W'(deriv_gain_i);
      end else begin
        dterm4_q <= '0;
      end
    end
  end

  assign res_o.pterm = pterm4_q;
  assign res_o.dterm = dterm4_q;

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.taken |=> $stable(pos_q) && $stable(delta_q))
    else $error("position changed without motion");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.ld[2] |=> (rem2_q < REM_W'(2 * DIVISOR)))
    else $error("reciprocal estimate off by more than one");

endmodule

### sv/ofph_merge.sv
// Sums and clamps both lanes' terms into the output beat register.
`timescale 1ns / 1ps

module ofph_merge (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 ld_i,
  input  ofph_pkg::lane_res_t                  res_x_i,
  input  ofph_pkg::lane_res_t                  res_y_i,
  input  logic                                 taken_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [ofph_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                                 m_axis_tuser_o
);
  import ofph_pkg::*;

  localparam logic signed [SUM_W-1:0] LIM_P = SUM_W'(DRIVE_LIMIT);
  localparam logic signed [SUM_W-1:0] LIM_N = -LIM_P;

  logic                        valid_q, valid_d;
  logic [DRIVE_W-1:0]          drv_x_q, drv_y_q, drv_x_d, drv_y_d;
  logic                        tk_q;
  logic signed [SUM_W-1:0]     sum_x, sum_y;

  function automatic logic [DRIVE_W-1:0] clamp(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] c;
    c = s;
    if (s > LIM_P) c = LIM_P;
    if (s < LIM_N) c = LIM_N;
    return c[DRIVE_W-1:0];
  endfunction

  assign sum_x   = SUM_W'(res_x_i.dterm) - SUM_W'(res_x_i.pterm);
  assign sum_y   = SUM_W'(res_y_i.dterm) - SUM_W'(res_y_i.pterm);
  assign drv_x_d = clamp(sum_x);
  assign drv_y_d = clamp(sum_y);

  always_comb begin
    valid_d = valid_q;
    if (ld_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      drv_x_q <= drv_x_d;
      drv_y_q <= drv_y_d;
      tk_q    <= taken_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - 2*DRIVE_W){1'b0}}, drv_y_q, drv_x_q};
  assign m_axis_tuser_o  = tk_q;

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (signed'(drv_x_q) <= DRIVE_W'(DRIVE_LIMIT)) &&
                (signed'(drv_x_q) >= -DRIVE_W'(DRIVE_LIMIT)) &&
                (signed'(drv_y_q) <= DRIVE_W'(DRIVE_LIMIT)) &&
                (signed'(drv_y_q) >= -DRIVE_W'(DRIVE_LIMIT)))
    else $error("drive beyond limit");

endmodule

### sv/optical_flow_position_hold_pd_top.sv
// Top level of the optical-flow position-hold PD controller.
//
//  port group    dir  payload (low bit first)
//  s_axis_*      in   tdata: motion_status[7:0], raw_delta_x[15:8], raw_delta_y[23:16]
//  m_axis_*      out  tdata: drive_x[14:0], drive_y[29:15], zero pad; tuser: motion_taken
//  cfg_*         in   index 0 prop_gain, 1 deriv_gain (signed Q8.8)
//
// One beat per cycle sustained while the output is not back-pressured; the position
// accumulators close their loop in the accept cycle, the rest is a feed-forward
// pipeline per axis lane. An accepted beat passes the snapshot, reciprocal multiply,
// remainder, quotient fix, gain multiply and sum/clamp registers to result valid.
// Reset clears gains, positions, last deltas and all stage valids.
// Stalls: each stage loads when empty or draining, so bubbles close up and
// input is still taken while a finished result waits at the output.
`timescale 1ns / 1ps

module optical_flow_position_hold_pd_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // motion reports
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [ofph_pkg::IN_DATA_W-1:0]        s_axis_tdata,   // status, dx, dy
  // drive results
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [ofph_pkg::OUT_DATA_W-1:0]       m_axis_tdata,   // drive_x, drive_y, pad
  output logic                                  m_axis_tuser,   // motion_taken
  // register writes
  input  logic                                  cfg_we_i,
  input  logic [ofph_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ofph_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);
  import ofph_pkg::*;

  logic signed [GAIN_W-1:0] prop_gain_q, prop_gain_d;
  logic signed [GAIN_W-1:0] deriv_gain_q, deriv_gain_d;

  logic [STATUS_W-1:0] motion_status;
  logic [DELTA_W-1:0]  raw_delta_x, raw_delta_y;

  logic [NSTG-1:0] v_q, v_d;     // stage valids
  logic [NSTG-1:0] tk_q;         // motion_taken carried along the stages
  logic [NSTG-1:0] ld;
  logic            ld_out;
  lane_ctl_t       ctl;
  lane_res_t       res_x, res_y;

  assign motion_status = s_axis_tdata[STATUS_W-1:0];
  assign raw_delta_x   = s_axis_tdata[STATUS_W +: DELTA_W];
  assign raw_delta_y   = s_axis_tdata[STATUS_W+DELTA_W +: DELTA_W];

  // config: must only be written while idle; the block itself does not enforce this
  always_comb begin
    prop_gain_d  = prop_gain_q;
    deriv_gain_d = deriv_gain_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_PROP_GAIN:  prop_gain_d  = signed'(cfg_wdata_i);
        CFG_DERIV_GAIN: deriv_gain_d = signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // load enables ripple back from the output register
  always_comb begin
    logic nxt;
    ld_out = v_q[NSTG-1] && (!m_axis_tvalid || m_axis_tready);
    nxt    = ld_out;
    for (int k = NSTG - 1; k >= 1; k--) begin
      ld[k] = v_q[k-1] && (!v_q[k] || nxt);
      nxt   = ld[k];
    end
    s_axis_tready = !v_q[0] || nxt;
    ld[0]         = s_axis_tvalid && s_axis_tready;
  end

  always_comb begin
    for (int k = 0; k < NSTG - 1; k++) begin
      v_d[k] = ld[k] || (v_q[k] && !ld[k+1]);
    end
    v_d[NSTG-1] = ld[NSTG-1] || (v_q[NSTG-1] && !ld_out);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= '0;
      deriv_gain_q <= '0;
      v_q          <= '0;
    end else begin
      prop_gain_q  <= prop_gain_d;
      deriv_gain_q <= deriv_gain_d;
      v_q          <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      tk_q[0] <= motion_status[MOTION_BIT];
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ld[k]) begin
        tk_q[k] <= tk_q[k-1];
      end
    end
  end

  assign ctl.taken = ld[0] && motion_status[MOTION_BIT];
  assign ctl.ld    = ld;

  ofph_lane u_lane_x (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .raw_delta_i  (raw_delta_x),
    .prop_gain_i  (prop_gain_q),
    .deriv_gain_i (deriv_gain_q),
    .res_o        (res_x)
  );

  ofph_lane u_lane_y (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .raw_delta_i  (raw_delta_y),
    .prop_gain_i  (prop_gain_q),
    .deriv_gain_i (deriv_gain_q),
    .res_o        (res_y)
  );

  ofph_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ld_i            (ld_out),
    .res_x_i         (res_x),
    .res_y_i         (res_y),
    .taken_i         (tk_q[NSTG-1]),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> v_q[0] && v_q[NSTG-1] && m_axis_tvalid)
    else $error("input stalled with room in the pipeline");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !ld_out)
    else $error("output register overwritten while stalled");

endmodule

### test/testbench.sv
// Self-checking testbench for the optical-flow position-hold PD controller.
`timescale 1ns / 1ps

module testbench;
  import ofph_pkg::*;

  // Pipeline depth from accepted report to drive beat.
  localparam int PIPE_LAT    = 6;
  // Long receiver hold-off; far longer than the pipeline can buffer.
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BEATS = 210;
  localparam int NUM_PHASES  = 8;
  localparam int PRESSURE_PH = 3;
  // Generous wall-clock limit in ns, with an 8 ns clock period.
  localparam longint LIMIT_NS = 64'd4_000_000;

  // A motion report as it sits on s_axis_tdata (status in the low byte).
  typedef struct packed {
    logic [7:0] dy;
    logic [7:0] dx;
    logic [7:0] status;
  } report_t;

  // One drive beat as the predictor sees it.
  typedef struct packed {
    logic [DRIVE_W-1:0] drive_x;
    logic [DRIVE_W-1:0] drive_y;
    logic               taken;
  } drive_beat_t;

  // ---------------------------------------------------------------------------
  // Drive predictor and scoreboard: own copy of gains, positions and deltas.
  // ---------------------------------------------------------------------------
  class drive_scoreboard;
    logic signed [GAIN_W-1:0]  prop_gain  = '0;
    logic signed [GAIN_W-1:0]  deriv_gain = '0;
    logic signed [POS_W-1:0]   pos_x      = '0;
    logic signed [POS_W-1:0]   pos_y      = '0;
    logic signed [DELTA_W-1:0] held_dx    = '0;
    logic signed [DELTA_W-1:0] held_dy    = '0;
    drive_beat_t               drive_q[$];
    int                        mismatches  = 0;
    int                        beats_seen  = 0;
    int                        reports     = 0;
    int                        motion_seen = 0;
    int                        clamp_hits  = 0;

    function void set_gain(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_PROP_GAIN) prop_gain = val;
      else deriv_gain = val;
    endfunction

    // Saturating add at the accumulator width.
    function logic signed [POS_W-1:0] sat_accum(logic signed [POS_W-1:0] acc,
                                                logic signed [DELTA_W-1:0] d);
      longint hi, lo, s;
      hi = (longint'(1) <<< (POS_W - 1)) - 1;
      lo = -hi - 1;
      s  = longint'(acc) + longint'(d);
      if (s > hi) s = hi;
      if (s < lo) s = lo;
      return s[POS_W-1:0];
    endfunction

    // -P*(pos/100) - D*(delta/100), exact, then clamped to +/-60.0.
    function logic [DRIVE_W-1:0] axis_drive(logic signed [POS_W-1:0] pos,
                                            logic signed [DELTA_W-1:0] d);
      longint v;
      v = -(longint'(prop_gain) * (longint'(pos) / DIVISOR))
          - (longint'(deriv_gain) * (longint'(d) / DIVISOR));
      if (v > DRIVE_LIMIT) begin
        v = DRIVE_LIMIT;
        clamp_hits++;
      end else if (v < -DRIVE_LIMIT) begin
        v = -DRIVE_LIMIT;
        clamp_hits++;
      end
      return v[DRIVE_W-1:0];
    endfunction

    function void note_report(report_t rep);
      drive_beat_t b;
      b.taken = rep.status[MOTION_BIT];
      if (b.taken) begin
        held_dx = rep.dx;
        held_dy = rep.dy;
        pos_x   = sat_accum(pos_x, held_dx);
        pos_y   = sat_accum(pos_y, held_dy);
        motion_seen++;
      end
      b.drive_x = axis_drive(pos_x, held_dx);
      b.drive_y = axis_drive(pos_y, held_dy);
      reports++;
      drive_q.push_back(b);
    endfunction

    function void report_mismatch(string what, int exp_v, int got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %s: expected %0d got %0d", $time, what, exp_v, got_v);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic taken);
      drive_beat_t got, want;
      got.drive_x = data[DRIVE_W-1:0];
      got.drive_y = data[2*DRIVE_W-1:DRIVE_W];
      got.taken   = taken;
      beats_seen++;
      if (drive_q.size() == 0) begin
        report_mismatch("beat with nothing pending, drive_x", 0,
                        int'($signed(got.drive_x)));
        return;
      end
      want = drive_q.pop_front();
      if (got.drive_x !== want.drive_x)
        report_mismatch("drive_x", int'($signed(want.drive_x)), int'($signed(got.drive_x)));
      if (got.drive_y !== want.drive_y)
        report_mismatch("drive_y", int'($signed(want.drive_y)), int'($signed(got.drive_y)));
      if (got.taken !== want.taken)
        report_mismatch("motion_taken", int'(want.taken), int'(got.taken));
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports, all known from time zero.
  // ---------------------------------------------------------------------------
  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  // Sender-to-receiver flags: a long hold-off request and the no-idle tail.
  bit hold_req   = 1'b0;
  bit quiet_tail = 1'b0;
  int gain_sets  = 0;

  drive_scoreboard sb = new();

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  optical_flow_position_hold_pd_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Output monitor: every accepted drive beat goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Receiver: random ready/stall bursts, one long hold-off on request,
  // ready held high throughout the tail.
  initial begin
    int hold_left;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(posedge clk_i);
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat (quiet_tail ? 1 : $urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic report_t mk(logic [7:0] st, logic [7:0] dx, logic [7:0] dy);
    report_t r;
    r.status = st;
    r.dx     = dx;
    r.dy     = dy;
    return r;
  endfunction

  // Displacement byte: mostly drifting in the bias direction so positions
  // wander far enough to reach the clamp, with full-range and corner bytes mixed in.
  function automatic logic [7:0] pick_delta(int bias);
    int          mode, mag;
    bit          neg;
    logic [7:0]  corners[8];
    corners = '{8'h7F, 8'h80, 8'h64, 8'h9C, 8'h63, 8'h9D, 8'h00, 8'hFF};
    mode = $urandom_range(0, 9);
    if (mode < 2) return 8'($urandom);
    if (mode == 2) return corners[$urandom_range(0, 7)];
    if (bias == 0) neg = $urandom_range(0, 1);
    else neg = ($urandom_range(0, 4) == 0) ? (bias > 0) : (bias < 0);
    if (neg) begin
      mag = $urandom_range(1, 128);
      return 8'(-mag);
    end
    mag = $urandom_range(0, 127);
    return 8'(mag);
  endfunction

  function automatic report_t random_report(int bias_x, int bias_y);
    logic [7:0] st;
    st = 8'($urandom);
    // About 70% of reports carry motion; the low status bits stay random.
    st[MOTION_BIT] = ($urandom_range(0, 9) < 7);
    return mk(st, pick_delta(bias_x), pick_delta(bias_y));
  endfunction

  // Offer one report and hold it until taken; optionally idle afterwards.
  task automatic send_report(report_t rep, bit allow_gap);
    s_axis_tdata  <= rep;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_report(rep);
    if (allow_gap && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every pending drive beat has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Both gain registers, written back to back while the block is idle.
  task automatic write_gains(logic [CFG_DATA_W-1:0] pg, logic [CFG_DATA_W-1:0] dg);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PROP_GAIN;
    cfg_wdata_i <= pg;
    @(posedge clk_i);
    sb.set_gain(CFG_PROP_GAIN, pg);
    cfg_idx_i   <= CFG_DERIV_GAIN;
    cfg_wdata_i <= dg;
    @(posedge clk_i);
    sb.set_gain(CFG_DERIV_GAIN, dg);
    cfg_we_i    <= 1'b0;
    gain_sets++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int               ph, n, bx, by;
    logic [GAIN_W-1:0] pg, dg;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset gains: drives must stay at zero, state still moves.
    send_report(mk(8'h00, 8'hFF, 8'h80), 1'b0);   // no motion, bytes ignored
    send_report(mk(8'h80, 8'h7F, 8'h80), 1'b0);   // displacement extremes
    send_report(mk(8'hFF, 8'h80, 8'h7F), 1'b0);   // motion with all status bits
    send_report(mk(8'h7F, 8'h12, 8'h34), 1'b0);   // low status bits only: no motion
    drain();

    // Unity gains: derivative term only fires for |delta| >= 100.
    write_gains(16'sd256, 16'sd256);
    send_report(mk(8'h80, 8'h64, 8'h9C), 1'b0);
    send_report(mk(8'h80, 8'h63, 8'h9D), 1'b0);
    send_report(mk(8'h00, 8'h55, 8'hAA), 1'b0);   // held deltas reused
    send_report(mk(8'h80, 8'h7F, 8'h7F), 1'b0);
    send_report(mk(8'h80, 8'h7F, 8'h80), 1'b0);
    send_report(mk(8'hC0, 8'h80, 8'h80), 1'b0);
    send_report(mk(8'h80, 8'h00, 8'h00), 1'b0);
    send_report(mk(8'h80, 8'hFF, 8'h01), 1'b0);
    send_report(mk(8'h01, 8'h7F, 8'h7F), 1'b0);
    send_report(mk(8'h80, 8'h9C, 8'h64), 1'b0);
    send_report(mk(8'h80, 8'h7F, 8'h7F), 1'b0);
    send_report(mk(8'h80, 8'h7F, 8'h7F), 1'b0);
    drain();

    // Extreme gains: once |position| >= 100 the proportional term alone exceeds the drive limit.
    write_gains(16'h8000, 16'h7FFF);
    send_report(mk(8'h80, 8'h7F, 8'h80), 1'b0);
    send_report(mk(8'h80, 8'h7F, 8'h80), 1'b0);
    send_report(mk(8'h00, 8'h00, 8'h00), 1'b0);
    send_report(mk(8'h80, 8'h9C, 8'h9C), 1'b0);
    send_report(mk(8'h80, 8'h64, 8'h64), 1'b0);
    send_report(mk(8'hFF, 8'hFF, 8'hFF), 1'b0);
    drain();

    // Random phases, one gain setting each, drained before the next write.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin pg = 16'sd1;    dg = -16'sd1;  end
        1:       begin pg = 16'h7FFF;  dg = 16'h8000; end
        3:       begin pg = -16'sd256; dg = 16'sd512; end
        4:       begin pg = 16'($urandom_range(0, 1023) - 512);
                       dg = 16'($urandom_range(0, 1023) - 512); end
        5:       begin pg = 16'h8000;  dg = 16'h8000; end
        7:       begin pg = 16'sd64;   dg = 16'h7FFF; end
        default: begin pg = 16'($urandom); dg = 16'($urandom); end
      endcase
      write_gains(pg, dg);
      bx = int'($urandom_range(0, 2)) - 1;
      by = int'($urandom_range(0, 2)) - 1;
      // Receiver stalls for a long stretch while reports keep coming.
      if (ph == PRESSURE_PH) hold_req = 1'b1;
      if (ph == NUM_PHASES - 1) quiet_tail = 1'b1;
      for (n = 0; n < PHASE_BEATS; n++)
        send_report(random_report(bx, by), !quiet_tail);
      drain();
    end

    // Settle: any stray beat after this point shows up as unexpected.
    repeat (4 * PIPE_LAT) @(posedge clk_i);

    $display("covered %0d reports (%0d with motion), %0d gain settings, %0d clamped drives",
             sb.reports, sb.motion_seen, gain_sets, sb.clamp_hits);
    $display("drive beats checked: %0d, mismatches: %0d, still pending: %0d",
             sb.beats_seen, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### optical_flow_position_hold_pd_top.f
sv/ofph_pkg.sv
sv/ofph_lane.sv
sv/ofph_merge.sv
sv/optical_flow_position_hold_pd_top.sv
test/testbench.sv
